@@ sv/polyline_segment_penalty_macros.svh @@
// Assertion helpers for the block's RTL.
`ifndef POLYLINE_SEGMENT_PENALTY_MACROS_SVH
`define POLYLINE_SEGMENT_PENALTY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PSP_ASSERT(lbl, prop, msg)
`define PSP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ sv/psp_pkg.sv @@
package psp_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned CoordInW     = 12;
  localparam int unsigned LimW         = 8;
  localparam logic [LimW-1:0] LimReset = 8'd16;
  localparam int unsigned IdxOutW      = 6;
  localparam int unsigned PenW         = 32;

  typedef struct packed {
    logic vld;
    logic busy;
  } pipe_stat_t;

endpackage

@@ sv/psp_point_mem.sv @@
module psp_point_mem #(
  parameter int unsigned Depth = psp_pkg::MaxPointsDef,
  parameter int unsigned Width = 2 * psp_pkg::CoordBitsDef,
  parameter int unsigned AddrW = $clog2(psp_pkg::MaxPointsDef)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/psp_cross_pipe.sv @@
module psp_cross_pipe #(
  parameter int unsigned CoordBits = psp_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [CoordBits-1:0]        xj_i,
  input  logic [CoordBits-1:0]        yj_i,
  input  logic [CoordBits-1:0]        xi_i,
  input  logic [CoordBits-1:0]        yi_i,
  input  logic signed [CoordBits:0]   dx_i,
  input  logic signed [CoordBits:0]   dy_i,
  output logic [4*CoordBits+3:0]      sq_o,
  output psp_pkg::pipe_stat_t         stat_o
);

  import psp_pkg::*;

  localparam int unsigned PW = 2 * CoordBits + 2;
  localparam int unsigned DW = PW + 1;
  localparam int unsigned SW = 4 * CoordBits + 4;

  logic signed [CoordBits:0] cx, cy;
  logic signed [PW-1:0]      p1_d, p2_d, p1_q, p2_q;
  logic signed [DW-1:0]      diff;
  logic [PW-1:0]             abs_d, abs_q;
  logic [SW-1:0]             sq_d, sq_q;
  logic                      v1_q, v2_q, v3_q;

  // cross of (Pj - Pi) with (Pk - Pi)
  assign cx   = $signed({1'b0, xj_i}) - $signed({1'b0, xi_i});
  assign cy   = $signed({1'b0, yj_i}) - $signed({1'b0, yi_i});
  assign p1_d = PW'(cx) * PW'(dy_i);
  assign p2_d = PW'(cy) * PW'(dx_i);
  assign diff = DW'(p1_q) - DW'(p2_q);
  assign abs_d = diff[DW-1] ? PW'(-diff) : PW'(diff);
  assign sq_d = SW'(abs_q) * SW'(abs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    abs_q <= abs_d;
    sq_q  <= sq_d;
  end

  assign sq_o        = sq_q;
  assign stat_o.vld  = v3_q;
  assign stat_o.busy = v1_q | v2_q | v3_q;

endmodule

@@ sv/psp_div_sqrt.sv @@
module psp_div_sqrt #(
  parameter int unsigned SumW = 4 * psp_pkg::CoordBitsDef + 4 + $clog2(psp_pkg::MaxPointsDef),
  parameter int unsigned IdxW = $clog2(psp_pkg::MaxPointsDef)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [SumW-1:0]          sum_i,
  input  logic [IdxW:0]            n_i,
  output logic                     done_o,
  output logic [psp_pkg::PenW-1:0] root_o
);

  import psp_pkg::*;

  localparam int unsigned ScaleSh = 16;  // penalty^2 scaled by 2^16 before the root
  localparam int unsigned NumW    = SumW + ScaleSh;
  localparam int unsigned RadW    = 2 * PenW;
  localparam int unsigned DivW    = (NumW > RadW) ? NumW : RadW + 1;
  localparam int unsigned RemW    = IdxW + 2;
  localparam int unsigned CntW    = $clog2(DivW + 1);
  localparam int unsigned SremW   = PenW + 2;
  localparam int unsigned TrialW  = PenW + 4;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CHK, S_SQRT} state_e;

  state_e             state_q;
  logic [DivW-1:0]    dvd_q;
  logic [RemW-1:0]    rem_q, rem_sh, rem_d;
  logic [IdxW:0]      n_q;
  logic [CntW-1:0]    cnt_q;
  logic               dge;
  logic [RadW-1:0]    rad_q;
  logic [PenW-1:0]    r_q, r_d, root_q;
  logic [SremW-1:0]   srem_q, srem_d;
  logic [TrialW-1:0]  srem_sh, trial;
  logic               sge;
  logic               done_q;

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_q[RemW-2:0], dvd_q[DivW-1]};
  assign dge    = rem_sh >= RemW'(n_q);
  assign rem_d  = dge ? rem_sh - RemW'(n_q) : rem_sh;

  // digit-by-digit root, one result bit a cycle
  assign srem_sh = {srem_q, rad_q[RadW-1:RadW-2]};
  assign trial   = TrialW'({r_q, 2'b01});
  assign sge     = srem_sh >= trial;
  assign srem_d  = sge ? SremW'(srem_sh - trial) : SremW'(srem_sh);
  assign r_d     = {r_q[PenW-2:0], sge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      root_q  <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      rad_q   <= '0;
      r_q     <= '0;
      srem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            dvd_q   <= DivW'({sum_i, {ScaleSh{1'b0}}});
            rem_q   <= '0;
            n_q     <= n_i;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[DivW-2:0], dge};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(DivW - 1)) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (|dvd_q[DivW-1:RadW]) begin
            root_q  <= '1;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            rad_q   <= dvd_q[RadW-1:0];
            r_q     <= '0;
            srem_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          srem_q <= srem_d;
          r_q    <= r_d;
          rad_q  <= {rad_q[RadW-3:0], 2'b00};
          cnt_q  <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(PenW - 1)) begin
            root_q  <= r_d;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ sv/polyline_segment_penalty.sv @@
// Polyline segment test and penalty.
// Input channel (in_valid_i/in_ready_o): one chain point per word, x, y and a
// chain_start flag that restarts the chain at index 0. Point k is stored in a
// point memory; it then yields k result words, one per earlier point i in
// rising order, on the output channel (out_valid_o/out_ready_i). The last word
// of a run has last_of_run_o set. The first point of a chain and a point that
// arrives when the store is full yield no word.
// Per result word the block reads point i, computes the segment length and
// bound, streams the k-i-1 interior points through the cross-product pipe at
// one a cycle and lets the pipe drain; a valid segment with nonzero deviation
// then also runs the divide/root unit, which dominates the time of a point.
// in_ready_o is high only while no point is being processed. A finished word
// sits in an output register; the next pair's work goes on until that
// register is needed again, so a stalled receiver stalls the block after one
// word. After the last word is registered a new point can be taken.
// Reset empties the chain and sets deviation_limit to 16; no memory clearing.
`include "polyline_segment_penalty_macros.svh"

module polyline_segment_penalty #(
  parameter int unsigned MaxPoints = psp_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = psp_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psp_pkg::LimW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [psp_pkg::CoordInW-1:0] x_coord_i,
  input  logic [psp_pkg::CoordInW-1:0] y_coord_i,
  input  logic                         chain_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [psp_pkg::IdxOutW-1:0]  from_index_o,
  output logic [psp_pkg::IdxOutW-1:0]  to_index_o,
  output logic                         segment_valid_o,
  output logic [psp_pkg::PenW-1:0]     penalty_o,
  output logic                         last_of_run_o
);

  import psp_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxPoints);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned PtW   = 2 * CoordBits;
  localparam int unsigned SqW   = 4 * CoordBits + 4;
  localparam int unsigned SumW  = SqW + IdxW;
  localparam int unsigned LenW  = 2 * CoordBits + 2;
  localparam int unsigned LsqW  = 2 * LimW;
  localparam int unsigned RhsW  = LenW + LsqW;
  localparam int unsigned DevSh = 8;  // limit is in sixteenths: cross^2 * 256
  localparam int unsigned CmpW  = SqW + DevSh;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_I, ST_WAIT_I, ST_LEN, ST_RHS, ST_SCAN, ST_DRAIN, ST_MATH, ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [LimW-1:0]          lim_q;
  logic [CntW-1:0]          cnt_q, base;
  logic [IdxW-1:0]          k_q, i_q, j_q, raddr;
  logic [CoordBits-1:0]     xin, yin, xk_q, yk_q, xi_q, yi_q, rx, ry;
  logic signed [CoordBits:0] dx_q, dy_q;
  logic signed [LenW-1:0]   sqx, sqy;
  logic [LenW-1:0]          len2_q;
  logic [LsqW-1:0]          limsq_q;
  logic [RhsW-1:0]          rhs_q;
  logic [SumW-1:0]          sum_q;
  logic                     fail_q, seg_ok_q, rd_vld_q;
  logic [PenW-1:0]          pen_q, root;
  logic                     accept, store, mem_we, seg_ok, drain_done, math_start, math_done;
  logic                     emit_ld;
  logic [PtW-1:0]           rdata;
  logic [SqW-1:0]           pipe_sq;
  pipe_stat_t               pstat;
  logic [IdxW:0]            n_pts;
  logic                     out_vld_q, segv_q, last_q;
  logic [IdxW-1:0]          from_q, to_q;
  logic [PenW-1:0]          pen_out_q;

  assign xin    = CoordBits'(x_coord_i);
  assign yin    = CoordBits'(y_coord_i);
  assign accept = in_valid_i && in_ready_o;
  assign base   = chain_start_i ? '0 : cnt_q;
  assign store  = base < CntW'(MaxPoints);
  assign mem_we = accept && store;
  assign raddr  = (state_q == ST_SCAN) ? j_q : i_q;
  assign rx     = rdata[CoordBits-1:0];
  assign ry     = rdata[PtW-1:CoordBits];

  assign sqx = LenW'(dx_q) * LenW'(dx_q);
  assign sqy = LenW'(dy_q) * LenW'(dy_q);

  assign drain_done = !rd_vld_q && !pstat.busy;
  assign seg_ok     = !fail_q || (len2_q == '0);
  assign math_start = (state_q == ST_DRAIN) && drain_done && seg_ok && (sum_q != '0);
  assign n_pts      = (IdxW + 1)'(k_q) - (IdxW + 1)'(i_q) + (IdxW + 1)'(1);
  assign emit_ld    = (state_q == ST_EMIT) && (!out_vld_q || out_ready_i);

  psp_point_mem #(
    .Depth (MaxPoints),
    .Width (PtW),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (base[IdxW-1:0]),
    .wdata_i ({yin, xin}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  psp_cross_pipe #(
    .CoordBits (CoordBits)
  ) u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .xj_i   (rx),
    .yj_i   (ry),
    .xi_i   (xi_q),
    .yi_i   (yi_q),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .sq_o   (pipe_sq),
    .stat_o (pstat)
  );

  psp_div_sqrt #(
    .SumW (SumW),
    .IdxW (IdxW)
  ) u_math (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (math_start),
    .sum_i   (sum_q),
    .n_i     (n_pts),
    .done_o  (math_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lim_q     <= LimReset;
      cnt_q     <= '0;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      xk_q      <= '0;
      yk_q      <= '0;
      xi_q      <= '0;
      yi_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      len2_q    <= '0;
      limsq_q   <= '0;
      rhs_q     <= '0;
      sum_q     <= '0;
      fail_q    <= 1'b0;
      seg_ok_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      pen_q     <= '0;
      out_vld_q <= 1'b0;
      from_q    <= '0;
      to_q      <= '0;
      segv_q    <= 1'b0;
      pen_out_q <= '0;
      last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      rd_vld_q <= (state_q == ST_SCAN);

      // interior point results leave the pipe here
      if (pstat.vld) begin
        sum_q <= sum_q + SumW'(pipe_sq);
        if ({pipe_sq, {DevSh{1'b0}}} >= CmpW'(rhs_q)) begin
          fail_q <= 1'b1;
        end
      end

      if (out_vld_q && out_ready_i && !emit_ld) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (mem_we) begin
            cnt_q <= base + CntW'(1);
            k_q   <= base[IdxW-1:0];
            xk_q  <= xin;
            yk_q  <= yin;
            i_q   <= '0;
            if (base != '0) begin
              state_q <= ST_RD_I;
            end
          end
        end
        ST_RD_I: state_q <= ST_WAIT_I;
        ST_WAIT_I: begin
          xi_q    <= rx;
          yi_q    <= ry;
          dx_q    <= $signed({1'b0, xk_q}) - $signed({1'b0, rx});
          dy_q    <= $signed({1'b0, yk_q}) - $signed({1'b0, ry});
          state_q <= ST_LEN;
        end
        ST_LEN: begin
          len2_q  <= $unsigned(sqx) + $unsigned(sqy);
          limsq_q <= LsqW'(lim_q) * LsqW'(lim_q);
          state_q <= ST_RHS;
        end
        ST_RHS: begin
          rhs_q  <= RhsW'(limsq_q) * RhsW'(len2_q);
          sum_q  <= '0;
          fail_q <= 1'b0;
          j_q    <= i_q + IdxW'(1);
          if ((i_q + IdxW'(1)) == k_q) begin
            state_q <= ST_DRAIN;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          j_q <= j_q + IdxW'(1);
          if ((j_q + IdxW'(1)) == k_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            seg_ok_q <= seg_ok;
            pen_q    <= '0;
            state_q  <= math_start ? ST_MATH : ST_EMIT;
          end
        end
        ST_MATH: begin
          if (math_done) begin
            pen_q   <= root;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ld) begin
            out_vld_q <= 1'b1;
            from_q    <= i_q;
            to_q      <= k_q;
            segv_q    <= seg_ok_q;
            pen_out_q <= seg_ok_q ? pen_q : '0;
            last_q    <= (i_q + IdxW'(1)) == k_q;
            if ((i_q + IdxW'(1)) == k_q) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + IdxW'(1);
              state_q <= ST_RD_I;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_vld_q;
  assign from_index_o    = IdxOutW'(from_q);
  assign to_index_o      = IdxOutW'(to_q);
  assign segment_valid_o = segv_q;
  assign penalty_o       = pen_out_q;
  assign last_of_run_o   = last_q;

  `PSP_ASSERT_NEVER(a_cnt_range, cnt_q > CntW'(MaxPoints), "point count past store size")
  `PSP_ASSERT(a_last_adjacent, out_valid_o && last_of_run_o |-> (from_index_o + IdxOutW'(1)) == to_index_o, "last word not adjacent pair")
  `PSP_ASSERT(a_invalid_zero, out_valid_o && !segment_valid_o |-> penalty_o == '0, "invalid segment with penalty")
  `PSP_ASSERT(a_pipe_scope, pstat.busy |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN), "cross pipe busy outside scan")

endmodule

@@ tb/sv/polyline_segment_penalty_tb.sv @@
`timescale 1ns / 100ps

module polyline_segment_penalty_tb;
  import psp_pkg::*;

  localparam int unsigned NPts = MaxPointsDef;
  localparam logic [CoordInW-1:0] CoordMask = (1 << CoordBitsDef) - 1;

  typedef struct packed {
    logic [IdxOutW-1:0] from_idx;
    logic [IdxOutW-1:0] to_idx;
    logic               seg_ok;
    logic [PenW-1:0]    pen;
    logic               last;
  } seg_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LimW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CoordInW-1:0] x_coord_i = '0;
  logic [CoordInW-1:0] y_coord_i = '0;
  logic chain_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IdxOutW-1:0] from_index_o, to_index_o;
  logic segment_valid_o, last_of_run_o;
  logic [PenW-1:0] penalty_o;

  polyline_segment_penalty dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .x_coord_i, .y_coord_i, .chain_start_i,
    .out_valid_o, .out_ready_i, .from_index_o, .to_index_o,
    .segment_valid_o, .penalty_o, .last_of_run_o
  );

  // predictor state
  logic [CoordInW-1:0] px [NPts];
  logic [CoordInW-1:0] py [NPts];
  int unsigned n_stored = 0;
  logic [LimW-1:0] dev_lim = LimReset;

  seg_result_t pending_segs[$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_points = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #50000000;
    $display("FAIL polyline_segment_penalty");
    $finish;
  end

  function automatic logic straight_enough(int unsigned i, int unsigned k);
    longint xi, yi, dx, dy, cx, cy, cr;
    longint unsigned len2, rhs;
    logic [127:0] sq;
    xi = px[i]; yi = py[i];
    dx = longint'(px[k]) - xi;
    dy = longint'(py[k]) - yi;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return 1'b1;
    rhs = longint'(dev_lim) * longint'(dev_lim) * len2;
    for (int unsigned j = i + 1; j < k; j++) begin
      cx = longint'(px[j]) - xi;
      cy = longint'(py[j]) - yi;
      cr = cx * dy - cy * dx;
      if (cr < 0) cr = -cr;
      sq = 128'(cr * 16) * 128'(cr * 16);
      if (sq >= 128'(rhs)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [PenW-1:0] seg_penalty(int unsigned i, int unsigned k);
    longint xi, yi, xk, yk, dx, dy, sx, sy, t;
    logic [127:0] acc, q, r;
    acc = '0;
    xi = px[i]; yi = py[i]; xk = px[k]; yk = py[k];
    dx = xk - xi; dy = yk - yi; sx = xi + xk; sy = yi + yk;
    for (int unsigned j = i; j <= k; j++) begin
      t = dx * (2 * longint'(py[j]) - sy) - dy * (2 * longint'(px[j]) - sx);
      if (t < 0) t = -t;
      acc += 128'(t) * 128'(t);
    end
    acc = (acc << 14) / (k - i + 1);
    if (acc[127:64] != 0) return '1;
    // bitwise integer root
    q = '0; r = acc;
    for (int b = 31; b >= 0; b--)
      if ((q | (128'(1) << b)) * (q | (128'(1) << b)) <= r) q |= 128'(1) << b;
    return q[PenW-1:0];
  endfunction

  task automatic predict_point(logic [CoordInW-1:0] x, logic [CoordInW-1:0] y,
                               logic first);
    seg_result_t e;
    int unsigned k;
    if (first) n_stored = 0;
    if (n_stored >= NPts) return;
    k = n_stored;
    px[k] = x & CoordMask;
    py[k] = y & CoordMask;
    n_stored = k + 1;
    for (int unsigned i = 0; i < k; i++) begin
      e.from_idx = IdxOutW'(i); e.to_idx = IdxOutW'(k);
      e.seg_ok = straight_enough(i, k);
      e.pen = e.seg_ok ? seg_penalty(i, k) : '0;
      e.last = (i + 1 == k);
      pending_segs.push_back(e);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    seg_result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_segs.size() == 0) begin
          report_mismatch("unexpected word, to_index", longint'(to_index_o), -64'sd1);
        end else begin
          e = pending_segs.pop_front();
          if (from_index_o !== e.from_idx)
            report_mismatch("from_index", longint'(from_index_o), longint'(e.from_idx));
          if (to_index_o !== e.to_idx)
            report_mismatch("to_index", longint'(to_index_o), longint'(e.to_idx));
          if (segment_valid_o !== e.seg_ok)
            report_mismatch("segment_valid", longint'(segment_valid_o), longint'(e.seg_ok));
          if (penalty_o !== e.pen)
            report_mismatch("penalty", longint'(penalty_o), longint'(e.pen));
          if (last_of_run_o !== e.last)
            report_mismatch("last_of_run", longint'(last_of_run_o), longint'(e.last));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays up after an accept; the next call either replaces the word or drops valid
  task automatic send_point(logic [CoordInW-1:0] x, logic [CoordInW-1:0] y, logic first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    chain_start_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_point(x, y, first);
    n_points++;
  endtask

  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    // a point can still be in flight after its last word
    while (!in_ready_o && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [LimW-1:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_lim = v;
  endtask

  task automatic test_directed();
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd4095, 12'd4095, 1'b0);
    send_point(12'd0, 12'd4095, 1'b0);
    send_point(12'd4095, 12'd0, 1'b0);
    send_point(12'd0, 12'd0, 1'b0);        // coincides with point 0
    send_point(12'd2048, 12'd2048, 1'b0);
    send_point(12'd10, 12'd10, 1'b1);
    send_point(12'd11, 12'd10, 1'b0);      // adjacent only
    send_point(12'd12, 12'd11, 1'b0);
    send_point(12'd13, 12'd10, 1'b0);
    send_point(12'd14, 12'd10, 1'b0);
    drain_results();                       // sender pauses until all words came
    send_point(12'd14, 12'd10, 1'b0);      // repeated point
    send_point(12'd2730, 12'd1365, 1'b0);
  endtask

  task automatic test_limits();
    set_limit(8'd1);
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd5, 12'd1, 1'b0);
    send_point(12'd10, 12'd1, 1'b0);
    send_point(12'd0, 12'd0, 1'b0);
    set_limit(8'd255);
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd30, 12'd20, 1'b0);
    send_point(12'd60, 12'd0, 1'b0);
    send_point(12'd0, 12'd1, 1'b0);
    set_limit(8'd16);
  endtask

  task automatic test_store_full();
    send_point(12'(100), 12'(100), 1'b1);
    for (int n = 1; n < int'(NPts) + 3; n++)
      send_point(12'(100 + n), 12'(100 + (n % 3)), 1'b0);
  endtask

  task automatic test_random(int unsigned count);
    logic [CoordInW-1:0] x, y;
    int unsigned span;
    x = '0; y = '0;
    span = 1;
    for (int unsigned n = 0; n < count; n++) begin
      if (n_stored == 0 || $urandom_range(9) == 0) begin
        span = $urandom_range(3) == 0 ? 4095 : 4;
        x = 12'($urandom_range(4095));
        y = 12'($urandom_range(4095));
        send_point(x, y, 1'b1);
      end else if (n_stored >= 14 && $urandom_range(3) != 0) begin
        send_point(12'($urandom_range(4095)), 12'($urandom_range(4095)), 1'b1);
      end else begin
        // mostly near-straight walks, sometimes wild jumps
        x = (span == 4095) ? 12'($urandom_range(4095)) : 12'(x + $urandom_range(3));
        y = (span == 4095) ? 12'($urandom_range(4095)) : 12'(y + $urandom_range(2));
        send_point(x, y, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 22; recv_idle_pct = 45;
    test_directed();
    test_limits();
    test_random(30);
    send_idle_pct = 45; recv_idle_pct = 22;
    set_limit(8'd40);
    test_random(30);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_limit(8'd3);
    test_random(20);
    set_limit(8'd16);
    test_store_full();
    drain_results();
    $display("covered %0d points, %0d segment words, limits 1..255, full store",
             n_points, n_results);
    if (n_errors == 0) $display("PASS polyline_segment_penalty");
    else $display("FAIL polyline_segment_penalty");
    $finish;
  end
endmodule
